[design/cmm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the compensated moving mean unit.
// No dependencies.

package cmm_pkg;

	localparam int unsigned MAX_ELEMENTS = 1024;
	localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);

	typedef logic [63:0] dbl_t;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_READ   = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	localparam dbl_t SIGN_MASK   = 64'h8000_0000_0000_0000;
	localparam dbl_t QUIET_BIT   = 64'h0008_0000_0000_0000;
	localparam dbl_t DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [10:0] EXP_MAX = 11'h7FF;

	function automatic logic is_nan(input dbl_t d);
		return (d[62:52] == EXP_MAX) && (d[51:0] != 52'd0);
	endfunction

	function automatic logic is_inf(input dbl_t d);
		return (d[62:52] == EXP_MAX) && (d[51:0] == 52'd0);
	endfunction

	function automatic dbl_t quiet(input dbl_t d);
		return d | QUIET_BIT;
	endfunction

endpackage

[design/cmm_fadd.sv]
`timescale 1ns / 1ps
// Double-precision adder, four stages: align, add, normalize, round.
// Depends on cmm_pkg.

module cmm_fadd import cmm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  dbl_t a,
	input  dbl_t b,
	input  logic sub,
	output logic done,
	output dbl_t y
);

	// stage 1: specials, swap, align
	dbl_t        bx, big, lit, spv;
	logic        spc, swap;
	logic [10:0] e_big, e_lit, dexp;
	logic [52:0] m_big, m_lit;
	logic [55:0] lit_ext, lit_sh, lit_mask, al;

	always_comb begin
		bx   = sub ? (b ^ SIGN_MASK) : b;
		spc  = (a[62:52] == EXP_MAX) || (b[62:52] == EXP_MAX);
		if (is_nan(a)) begin
			spv = quiet(a);
		end else if (is_nan(b)) begin
			spv = quiet(b);
		end else if (is_inf(a) && is_inf(bx) && (a[63] != bx[63])) begin
			spv = DEFAULT_NAN;
		end else if (is_inf(a)) begin
			spv = a;
		end else begin
			spv = bx;
		end
		swap  = b[62:0] > a[62:0];
		big   = swap ? bx : a;
		lit   = swap ? a : bx;
		e_big = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
		e_lit = (lit[62:52] == 11'd0) ? 11'd1 : lit[62:52];
		m_big = {big[62:52] != 11'd0, big[51:0]};
		m_lit = {lit[62:52] != 11'd0, lit[51:0]};
		dexp  = e_big - e_lit;
		lit_ext  = {m_lit, 3'b000};
		lit_sh   = lit_ext >> dexp[5:0];
		lit_mask = (56'd1 << dexp[5:0]) - 56'd1;
		if (dexp >= 11'd56) begin
			al = {55'd0, |m_lit};
		end else begin
			al = {lit_sh[55:1], lit_sh[0] | (|(lit_ext & lit_mask))};
		end
	end

	logic        v_s1, spc_s1, sgn_s1, esub_s1;
	dbl_t        spv_s1;
	logic [10:0] e_s1;
	logic [55:0] mb_s1, ml_s1;

	logic        v_s2, spc_s2, sgn_s2, esub_s2;
	dbl_t        spv_s2;
	logic [10:0] e_s2;
	logic [56:0] r_s2;

	logic        v_s3, spc_s3, sgn_s3;
	dbl_t        spv_s3;
	logic [11:0] e_s3;
	logic [55:0] n_s3;

	logic done_q;
	dbl_t y_q;

	// stage 3 comb: leading zero search and normalize
	logic [5:0]  lz, sh;
	logic [11:0] e_m1, e_n;
	logic [55:0] n_c;

	always_comb begin
		lz = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (r_s2[i]) begin
				lz = 6'(55 - i);
			end
		end
		e_m1 = 12'(e_s2) - 12'd1;
		sh   = (12'(lz) > e_m1) ? e_m1[5:0] : lz;
		if (r_s2[56]) begin
			n_c = {r_s2[56:2], r_s2[1] | r_s2[0]};
			e_n = 12'(e_s2) + 12'd1;
		end else begin
			n_c = r_s2[55:0] << sh;
			e_n = 12'(e_s2) - 12'(sh);
		end
	end

	// stage 4 comb: round to nearest even
	logic        up;
	logic [53:0] m_r;
	logic [11:0] fld;
	logic [51:0] frac;
	dbl_t        res;

	always_comb begin
		up  = n_s3[2] & (n_s3[1] | n_s3[0] | n_s3[3]);
		m_r = {1'b0, n_s3[55:3]} + 54'(up);
		if (m_r[53]) begin
			fld  = e_s3 + 12'd1;
			frac = m_r[52:1];
		end else begin
			fld  = m_r[52] ? e_s3 : 12'd0;
			frac = m_r[51:0];
		end
		if (fld >= 12'd2047) begin
			res = {sgn_s3, EXP_MAX, 52'd0};
		end else begin
			res = {sgn_s3, fld[10:0], frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		spc_s1  <= spc;
		spv_s1  <= spv;
		sgn_s1  <= big[63];
		esub_s1 <= big[63] ^ lit[63];
		e_s1    <= e_big;
		mb_s1   <= {m_big, 3'b000};
		ml_s1   <= al;

		spc_s2  <= spc_s1;
		spv_s2  <= spv_s1;
		sgn_s2  <= sgn_s1;
		esub_s2 <= esub_s1;
		e_s2    <= e_s1;
		r_s2    <= esub_s1 ? ({1'b0, mb_s1} - {1'b0, ml_s1}) : ({1'b0, mb_s1} + {1'b0, ml_s1});

		spc_s3  <= spc_s2;
		spv_s3  <= spv_s2;
		sgn_s3  <= ((r_s2 == 57'd0) && esub_s2) ? 1'b0 : sgn_s2;
		e_s3    <= e_n;
		n_s3    <= n_c;

		y_q     <= spc_s3 ? spv_s3 : res;
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

[design/cmm_fscale.sv]
`timescale 1ns / 1ps
// Scales a double by the rounded reciprocal of a 16-bit frame count.
// Radix-2 reciprocal, 27-bit partial-product multiply, round. Depends on cmm_pkg.

module cmm_fscale import cmm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  dbl_t        num,
	input  logic [15:0] count,
	output logic        done,
	output dbl_t        y
);

	typedef enum logic [6:0] {
		FS_IDLE = 7'b0000001,
		FS_DIV  = 7'b0000010,
		FS_RCP  = 7'b0000100,
		FS_MUL  = 7'b0001000,
		FS_LZC  = 7'b0010000,
		FS_SHF  = 7'b0100000,
		FS_RND  = 7'b1000000
	} fs_state_t;

	localparam logic [6:0] DIV_STEPS = 7'd69;

	fs_state_t state_q;
	logic [6:0]  it_q;
	logic [1:0]  pp_q;
	logic        done_q;

	dbl_t        num_q, y_q;
	logic [15:0] m16_q, rem_q;
	logic [3:0]  p_q;
	logic [54:0] q_q;
	logic [52:0] ma_q, mb_q;
	logic [10:0] ea_q, eb_q;
	logic [105:0] acc_q;
	logic signed [13:0] k_q, e_q;
	logic [52:0] mant_q;
	logic        g_q, st_q;

	// start: normalize divisor
	logic [15:0] n_c;
	logic [3:0]  p_c;
	always_comb begin
		n_c = (count == 16'd0) ? 16'd1 : count;
		p_c = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (n_c[i]) begin
				p_c = 4'(i);
			end
		end
	end

	// divide step
	logic [16:0] rem2;
	logic        ge;
	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge   = rem2 >= {1'b0, m16_q};
	end

	// reciprocal rounding and operand unpack
	logic        rup, spc;
	logic [53:0] rm;
	dbl_t        spv;
	logic [10:0] rexp;
	logic [51:0] rfrac;
	always_comb begin
		rup = q_q[0] & ((rem_q != 16'd0) | q_q[1]);
		rm  = {1'b0, q_q[53:1]} + 54'(rup);
		if (q_q[54]) begin
			rexp  = 11'd1023 - 11'(p_q);
			rfrac = 52'd0;
		end else if (rm[53]) begin
			rexp  = 11'd1023 - 11'(p_q);
			rfrac = 52'd0;
		end else begin
			rexp  = 11'd1022 - 11'(p_q);
			rfrac = rm[51:0];
		end
		spc = (num_q[62:52] == EXP_MAX) || (num_q[62:0] == 63'd0);
		if (is_nan(num_q)) begin
			spv = quiet(num_q);
		end else if (is_inf(num_q)) begin
			spv = num_q;
		end else begin
			spv = {num_q[63], 63'd0};
		end
	end

	// partial product
	logic [26:0]  op_a, op_b;
	logic [53:0]  prod;
	logic [105:0] prod_sh;
	always_comb begin
		op_a = pp_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		op_b = pp_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		prod = op_a * op_b;
		unique case (pp_q)
			2'd0:    prod_sh = 106'(prod);
			2'd3:    prod_sh = 106'(prod) << 54;
			default: prod_sh = 106'(prod) << 27;
		endcase
	end

	// leading one and shift amount
	logic [6:0] lead;
	logic signed [13:0] k1, k2, e_c;
	always_comb begin
		lead = 7'd0;
		for (int i = 0; i < 106; i++) begin
			if (acc_q[i]) begin
				lead = 7'(i);
			end
		end
		k1  = $signed(14'(lead)) - 14'sd52;
		k2  = 14'sd1076 - $signed(14'(ea_q)) - $signed(14'(eb_q));
		e_c = $signed(14'(lead)) + $signed(14'(ea_q)) + $signed(14'(eb_q)) - 14'sd1127;
	end

	// right shift with sticky
	logic [107:0] wide, ext, mask;
	logic [6:0]   kz;
	always_comb begin
		wide = {acc_q, 2'b00};
		kz   = k_q[6:0];
		ext  = wide >> kz;
		mask = (108'd1 << kz) - 108'd1;
	end

	// final rounding
	logic        up;
	logic [53:0] m_r;
	logic [11:0] fld, fld2;
	logic [51:0] frac;
	dbl_t        res;
	always_comb begin
		up   = g_q & (st_q | mant_q[0]);
		m_r  = {1'b0, mant_q} + 54'(up);
		fld  = (e_q >= 14'sd1) ? 12'(e_q) : 12'd0;
		if (m_r[53]) begin
			fld2 = fld + 12'd1;
			frac = m_r[52:1];
		end else if ((fld == 12'd0) && m_r[52]) begin
			fld2 = 12'd1;
			frac = m_r[51:0];
		end else begin
			fld2 = fld;
			frac = m_r[51:0];
		end
		if (fld2 >= 12'd2047) begin
			res = {num_q[63], EXP_MAX, 52'd0};
		end else begin
			res = {num_q[63], fld2[10:0], frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			it_q    <= 7'd0;
			pp_q    <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				FS_IDLE: begin
					if (start) begin
						state_q <= FS_DIV;
						it_q    <= 7'd0;
					end
				end
				FS_DIV: begin
					it_q <= it_q + 7'd1;
					if (it_q == DIV_STEPS - 7'd1) begin
						state_q <= FS_RCP;
					end
				end
				FS_RCP: begin
					pp_q <= 2'd0;
					if (spc) begin
						done_q  <= 1'b1;
						state_q <= FS_IDLE;
					end else begin
						state_q <= FS_MUL;
					end
				end
				FS_MUL: begin
					pp_q <= pp_q + 2'd1;
					if (pp_q == 2'd3) begin
						state_q <= FS_LZC;
					end
				end
				FS_LZC: state_q <= FS_SHF;
				FS_SHF: state_q <= FS_RND;
				FS_RND: begin
					done_q  <= 1'b1;
					state_q <= FS_IDLE;
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FS_IDLE: begin
				num_q <= num;
				p_q   <= p_c;
				m16_q <= n_c << (4'd15 - p_c);
				rem_q <= 16'd1;
				q_q   <= 55'd0;
			end
			FS_DIV: begin
				rem_q <= ge ? 16'(rem2 - {1'b0, m16_q}) : rem2[15:0];
				q_q   <= {q_q[53:0], ge};
			end
			FS_RCP: begin
				y_q   <= spv;
				eb_q  <= rexp;
				mb_q  <= {1'b1, rfrac};
				ea_q  <= (num_q[62:52] == 11'd0) ? 11'd1 : num_q[62:52];
				ma_q  <= {num_q[62:52] != 11'd0, num_q[51:0]};
				acc_q <= 106'd0;
			end
			FS_MUL: acc_q <= acc_q + prod_sh;
			FS_LZC: begin
				k_q <= (k1 > k2) ? k1 : k2;
				e_q <= e_c;
			end
			FS_SHF: begin
				if (k_q > 14'sd107) begin
					mant_q <= 53'd0;
					g_q    <= 1'b0;
					st_q   <= |acc_q;
				end else begin
					mant_q <= ext[54:2];
					g_q    <= ext[1];
					st_q   <= ext[0] | (|(wide & mask));
				end
			end
			FS_RND: y_q <= res;
			default: y_q <= y_q;
		endcase
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

[design/compensated_moving_mean_unit.sv]
`timescale 1ns / 1ps
// Top level of the compensated moving mean unit: state memory and sequencer.
// Depends on cmm_pkg, cmm_fadd, cmm_fscale.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  request | in_valid, in_stall, func, element,           | in
//          | value_bits, frame_count                      |
//  result  | out_valid, out_stall, mean_bits              | out
//
// Sequence: add/remove makes four passes through the 4-stage adder after a
// memory read; read makes one add pass, then the 69-step reciprocal divider,
// the partial-product multiply, normalize and round.
// After reset the memory is swept to zero, one entry per cycle, over all
// MAX_ELEMENTS (1024) entries; in_stall is high during the sweep.
// A finished mean sits in the output register while the next request runs;
// only a second mean waits on out_stall.

module compensated_moving_mean_unit import cmm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [9:0]  element,
	input  logic [63:0] value_bits,
	input  logic [15:0] frame_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] mean_bits
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_ADD   = 7'b0001000,
		ST_AWAIT = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [1:0]  step_q;
	logic        out_valid_q;

	// request payload and working values
	logic [ADDR_W-1:0] addr_q;
	logic        is_read_q, ge_q;
	dbl_t        x_q, s_q, c_q, t_q, res_q, mean_q;
	logic [15:0] count_q;

	// one memory holds {compensation, running sum} per element
	logic [127:0] st_mem [MAX_ELEMENTS];
	logic [127:0] rd_q;
	logic         mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [127:0] mem_wd;

	logic accept, in_range;
	func_t fn;

	logic fa_start, fa_sub, fa_done;
	dbl_t fa_a, fa_b, fa_y;
	logic fs_start, fs_done;
	dbl_t fs_y;
	logic out_load;

	assign fn       = func_t'(func);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = 32'(element) < MAX_ELEMENTS;

	// Adder operand select. Fold sequence:
	//   t = s + x; d = big - t; e = d + small; c = c + e
	// read: m = s + c
	always_comb begin
		fa_sub = 1'b0;
		if (is_read_q) begin
			fa_a = s_q;
			fa_b = c_q;
		end else begin
			unique case (step_q)
				2'd0: begin
					fa_a = s_q;
					fa_b = x_q;
				end
				2'd1: begin
					fa_a   = ge_q ? s_q : x_q;
					fa_b   = t_q;
					fa_sub = 1'b1;
				end
				2'd2: begin
					fa_a = res_q;
					fa_b = ge_q ? x_q : s_q;
				end
				default: begin
					fa_a = c_q;
					fa_b = res_q;
				end
			endcase
		end
	end

	assign fa_start = (state_q == ST_ADD);
	assign fs_start = (state_q == ST_AWAIT) && fa_done && is_read_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = {fa_y, t_q};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = 128'd0;
		end else if ((state_q == ST_AWAIT) && fa_done && !is_read_q && (step_q == 2'd3)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			st_mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rd_q <= st_mem[ADDR_W'(element)];
		end
	end

	cmm_fadd u_fadd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fa_start),
		.a      (fa_a),
		.b      (fa_b),
		.sub    (fa_sub),
		.done   (fa_done),
		.y      (fa_y)
	);

	cmm_fscale u_fscale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fs_start),
		.num    (fa_y),
		.count  (count_q),
		.done   (fs_done),
		.y      (fs_y)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					step_q <= 2'd0;
					if (accept) begin
						unique case (fn)
							FN_ADD, FN_REMOVE: begin
								if (in_range) begin
									state_q <= ST_READ;
								end
							end
							FN_READ: state_q <= in_range ? ST_READ : ST_OUT;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_AWAIT;
				ST_AWAIT: begin
					if (fa_done) begin
						if (is_read_q) begin
							state_q <= ST_SCALE;
						end else if (step_q == 2'd3) begin
							state_q <= ST_IDLE;
						end else begin
							step_q  <= step_q + 2'd1;
							state_q <= ST_ADD;
						end
					end
				end
				ST_SCALE: begin
					if (fs_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q    <= ADDR_W'(element);
			is_read_q <= (fn == FN_READ);
			x_q       <= (fn == FN_REMOVE) ? (value_bits ^ SIGN_MASK) : value_bits;
			count_q   <= frame_count;
			res_q     <= 64'd0;
		end
		if (state_q == ST_READ) begin
			s_q  <= rd_q[63:0];
			c_q  <= rd_q[127:64];
			// magnitude test is false when either side is NaN
			ge_q <= !is_nan(rd_q[63:0]) && !is_nan(x_q) && (rd_q[62:0] >= x_q[62:0]);
		end
		if ((state_q == ST_AWAIT) && fa_done) begin
			res_q <= fa_y;
			if (step_q == 2'd0) begin
				t_q <= fa_y;
			end
		end
		if ((state_q == ST_SCALE) && fs_done) begin
			res_q <= fs_y;
		end
		if (out_load) begin
			mean_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign mean_bits = mean_q;

endmodule
